FILE: hdl/assert_macros.svh
// Assertion macros for the RTL (included by lupd_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/lupd_pkg.sv
package lupd_pkg;
	localparam int MaxOrder = 8;
	localparam int IdxW = 3;
	localparam int AddrW = 6;
	localparam int ValW = 32;
	localparam int OneQShift = 24;
	localparam int DivQW = 56;

	typedef logic signed [ValW-1:0] val_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [AddrW-1:0] addr_t;

	// memory operand selects
	typedef enum logic [1:0] {
		RD_NONE, RD_A, RD_B
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic   wr_en;
		addr_t  wr_addr;
		logic   wr_src_in;   // 1: input word, 0: datapath result
		logic   rd_en;
		addr_t  rd_addr;
		rd_sel_t rd_dst;
		logic   piv_clear;
		logic   piv_cmp;
		idx_t   piv_row;
		logic   div_start;
		logic   mul_start;
		logic   res_to_m;    // latch division result as multiplier
		logic   wr_sel_b;    // write B register
		logic   wr_sel_m;    // write multiplier
		logic   wr_sel_upd;  // write update result
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic piv_found;
		idx_t piv_idx;
	} dp_sts_t;

	function automatic val_t sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return val_t'(32'h7fffffff);
		if (v < -64'sd2147483648) return val_t'(32'h80000000);
		return val_t'(v[31:0]);
	endfunction
endpackage

FILE: hdl/lupd_div.sv
// Restoring divider: (a<<24)/b, truncated toward zero, saturated
module lupd_div
	import lupd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  val_t num,
	input  val_t den,
	output logic done,
	output val_t quo
);
	localparam int CntW = $clog2(DivQW + 1);

	logic [DivQW-1:0] dvd_q;
	logic [DivQW-1:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic neg_q;
	logic busy_q;
	logic [CntW-1:0] cnt_q;
	logic [33:0] trial;
	logic signed [63:0] sq;

	assign trial = {rem_q, dvd_q[DivQW-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DivQW);
				dvd_q <= {(num[ValW-1] ? 24'(0) - 24'(0) : 24'(0)),
					(num[ValW-1] ? 32'(-num) : 32'(num))} << OneQShift;
				dvs_q <= den[ValW-1] ? 32'(-den) : 32'(den);
				neg_q <= num[ValW-1] ^ den[ValW-1];
				rem_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[DivQW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], dvd_q[DivQW-1]};
					quo_q <= {quo_q[DivQW-2:0], 1'b0};
				end
				dvd_q <= {dvd_q[DivQW-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({8'd0, quo_q}) : $signed({8'd0, quo_q});
		quo = sat64(sq);
	end
endmodule

FILE: hdl/lupd_dp.sv
// Datapath: matrix memory, operand registers, pivot search, divider, update
module lupd_dp
	import lupd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	input  val_t     in_word,
	output dp_sts_t  sts,
	output val_t     rd_word
);
	val_t mem [2**AddrW];
	val_t rdata_q;
	rd_sel_t dst_q;
	val_t a_q, b_q, m_q, upd_q;
	logic signed [63:0] prod_q;
	logic [31:0] best_q;
	logic found_q;
	idx_t idx_q;
	logic cmp_s1;
	idx_t row_s1;
	logic mul_s1, mul_s2;
	val_t wdata;
	val_t dq;
	logic [32:0] magn;

	// memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[cmd.rd_addr];
	end

	always_comb begin
		priority if (cmd.wr_src_in) wdata = in_word;
		else if (cmd.wr_sel_b) wdata = b_q;
		else if (cmd.wr_sel_m) wdata = m_q;
		else if (cmd.wr_sel_upd) wdata = upd_q;
		else wdata = a_q;
	end

	assign rd_word = rdata_q;
	assign magn = rdata_q[ValW-1] ? 33'(-{rdata_q[31], rdata_q}) : {1'b0, rdata_q};

	lupd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(a_q), .den(b_q), .done(sts.div_done), .quo(dq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_q <= RD_NONE;
			cmp_s1 <= 1'b0;
			row_s1 <= '0;
			mul_s1 <= 1'b0;
			mul_s2 <= 1'b0;
			found_q <= 1'b0;
			best_q <= '0;
			idx_q <= '0;
		end else begin
			dst_q <= cmd.rd_en ? cmd.rd_dst : RD_NONE;
			cmp_s1 <= cmd.piv_cmp;
			row_s1 <= cmd.piv_row;
			mul_s1 <= cmd.mul_start;
			mul_s2 <= mul_s1;
			// pivot search, strict greater keeps first max
			if (cmd.piv_clear) begin
				found_q <= 1'b0;
				best_q <= '0;
			end else if (cmp_s1 && ({1'b0, best_q} < magn)) begin
				best_q <= magn[31:0];
				found_q <= 1'b1;
				idx_q <= row_s1;
			end
		end
	end

	// operand capture, multiply, subtract
	always_ff @(posedge clk) begin
		unique case (dst_q)
			RD_A: a_q <= rdata_q;
			RD_B: b_q <= rdata_q;
			default: ;
		endcase
		if (cmd.res_to_m) m_q <= dq;
		if (cmd.mul_start) prod_q <= 64'(m_q) * 64'(b_q);
		if (mul_s1) upd_q <= sat64(64'(a_q) - (prod_q >>> OneQShift));
	end

	assign sts.mul_done = mul_s2;
	assign sts.piv_found = found_q;
	assign sts.piv_idx = idx_q;
endmodule

FILE: hdl/lupd_ctrl.sv
// Controller: load, pivot, swap, eliminate, stream out
module lupd_ctrl
	import lupd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  logic [3:0] cfg_data,
	output logic     cfg_ready,
	input  logic     s_tvalid,
	output logic     s_tready,
	output ctl_cmd_t cmd,
	input  dp_sts_t  sts,
	input  val_t     rd_word,
	output logic     m_tvalid,
	input  logic     m_tready,
	output logic [47:0] m_tdata,
	output logic     m_tuser,
	output logic     m_tlast
);
	typedef enum logic [4:0] {
		S_LOAD, S_PIV_RD, S_PIV_WAIT, S_PIV_DEC, S_SW_RDA, S_SW_RDB, S_SW_W1,
		S_SW_W2, S_EL_RDP, S_EL_RDA, S_EL_OPW, S_EL_DIV, S_EL_DIVW, S_EL_WM,
		S_EL_RDU, S_EL_RDX, S_EL_MUL, S_EL_WAIT, S_EL_WX, S_NEXT, S_OUT_RD,
		S_OUT_WAIT, S_OUT_HOLD
	} state_t;

	state_t state_q;
	idx_t n1_q;          // order minus one
	idx_t r_q, c_q, k_q, i_q, j_q;
	idx_t perm_q [MaxOrder];
	logic sing_q;
	logic [47:0] tdata_q;
	logic user_q;
	logic last_q;

	function automatic addr_t ad(input idx_t r, input idx_t c);
		return {r, c};
	endfunction

	assign cfg_ready = (state_q == S_LOAD);
	assign s_tready = (state_q == S_LOAD) && !cfg_valid;
	assign m_tdata = tdata_q;
	assign m_tuser = user_q;
	assign m_tlast = last_q;

	always_comb begin
		cmd = '0;
		cmd.wr_src_in = s_tvalid && s_tready;
		cmd.wr_en = s_tvalid && s_tready;
		cmd.wr_addr = ad(r_q, c_q);
		unique case (state_q)
			S_PIV_RD: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(i_q, k_q);
				cmd.piv_cmp = 1'b1; cmd.piv_row = i_q;
			end
			S_SW_RDA: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(k_q, j_q); cmd.rd_dst = RD_A;
			end
			S_SW_RDB: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(sts.piv_idx, j_q); cmd.rd_dst = RD_B;
			end
			// A is ready before B: write the pivot row first
			S_SW_W1: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = ad(sts.piv_idx, j_q);
			end
			S_SW_W2: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = ad(k_q, j_q); cmd.wr_sel_b = 1'b1;
			end
			S_EL_RDP: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(k_q, k_q); cmd.rd_dst = RD_B;
			end
			S_EL_RDA: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(i_q, k_q); cmd.rd_dst = RD_A;
			end
			S_EL_DIV: cmd.div_start = 1'b1;
			S_EL_DIVW: cmd.res_to_m = sts.div_done;
			S_EL_WM: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = ad(i_q, k_q); cmd.wr_sel_m = 1'b1;
			end
			S_EL_RDU: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(k_q, j_q); cmd.rd_dst = RD_B;
			end
			S_EL_RDX: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(i_q, j_q); cmd.rd_dst = RD_A;
			end
			S_EL_MUL: cmd.mul_start = 1'b1;
			S_EL_WX: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = ad(i_q, j_q); cmd.wr_sel_upd = 1'b1;
			end
			S_OUT_RD: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = ad(r_q, c_q);
			end
			S_NEXT: cmd.piv_clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			n1_q <= idx_t'(MaxOrder - 1);
			r_q <= '0; c_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0;
			sing_q <= 1'b0;
			m_tvalid <= 1'b0;
			tdata_q <= '0;
			user_q <= 1'b0;
			last_q <= 1'b0;
			for (int p = 0; p < MaxOrder; p++) perm_q[p] <= idx_t'(p);
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (cfg_valid) begin
						priority if (cfg_data < 4'd2) n1_q <= idx_t'(1);
						else if (cfg_data > 4'(MaxOrder)) n1_q <= idx_t'(MaxOrder - 1);
						else n1_q <= idx_t'(cfg_data - 4'd1);
						r_q <= '0; c_q <= '0;
					end else if (s_tvalid) begin
						c_q <= c_q + 1'b1;
						if (c_q == n1_q) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
							if (r_q == n1_q) begin
								r_q <= '0;
								k_q <= '0;
								i_q <= '0;
								sing_q <= 1'b0;
								for (int p = 0; p < MaxOrder; p++) perm_q[p] <= idx_t'(p);
								state_q <= S_NEXT;
							end
						end
					end
				end
				S_NEXT: begin
					i_q <= k_q;
					state_q <= S_PIV_RD;
				end
				S_PIV_RD: begin
					i_q <= i_q + 1'b1;
					if (i_q == n1_q) state_q <= S_PIV_WAIT;
				end
				S_PIV_WAIT: state_q <= S_PIV_DEC;
				S_PIV_DEC: begin
					j_q <= '0;
					if (!sts.piv_found) begin
						// no nonzero entry on or below the diagonal: flag it and move to the next column, or to output after the last
						sing_q <= 1'b1;
						if (k_q == n1_q) begin
							state_q <= S_OUT_RD;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_NEXT;
						end
					end else if (sts.piv_idx != k_q) begin
						perm_q[k_q] <= perm_q[sts.piv_idx];
						perm_q[sts.piv_idx] <= perm_q[k_q];
						state_q <= S_SW_RDA;
					end else begin
						i_q <= k_q + 1'b1;
						state_q <= (k_q == n1_q) ? S_OUT_RD : S_EL_RDP;
					end
				end
				S_SW_RDA: state_q <= S_SW_RDB;
				S_SW_RDB: state_q <= S_SW_W1;
				S_SW_W1: state_q <= S_SW_W2;
				S_SW_W2: begin
					j_q <= j_q + 1'b1;
					if (j_q == n1_q) begin
						i_q <= k_q + 1'b1;
						state_q <= (k_q == n1_q) ? S_OUT_RD : S_EL_RDP;
					end else state_q <= S_SW_RDA;
				end
				S_EL_RDP: state_q <= S_EL_RDA;
				S_EL_RDA: state_q <= S_EL_OPW;
				S_EL_OPW: state_q <= S_EL_DIV;
				S_EL_DIV: state_q <= S_EL_DIVW;
				S_EL_DIVW: if (sts.div_done) state_q <= S_EL_WM;
				S_EL_WM: begin
					j_q <= k_q + 1'b1;
					state_q <= S_EL_RDU;
				end
				S_EL_RDU: state_q <= S_EL_RDX;
				S_EL_RDX: state_q <= S_EL_MUL;
				S_EL_MUL: state_q <= S_EL_WAIT;
				S_EL_WAIT: if (sts.mul_done) state_q <= S_EL_WX;
				S_EL_WX: begin
					j_q <= j_q + 1'b1;
					if (j_q == n1_q) begin
						i_q <= i_q + 1'b1;
						if (i_q == n1_q) begin
							k_q <= k_q + 1'b1;
							state_q <= S_NEXT;
						end else state_q <= S_EL_RDP;
					end else state_q <= S_EL_RDU;
				end
				S_OUT_RD: state_q <= S_OUT_WAIT;
				S_OUT_WAIT: begin
					m_tvalid <= 1'b1;
					tdata_q <= {7'd0, perm_q[r_q], c_q, r_q, rd_word};
					user_q <= sing_q;
					last_q <= (r_q == n1_q) && (c_q == n1_q);
					state_q <= S_OUT_HOLD;
				end
				S_OUT_HOLD: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						c_q <= c_q + 1'b1;
						state_q <= S_OUT_RD;
						if (c_q == n1_q) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
							if (r_q == n1_q) begin
								r_q <= '0;
								state_q <= S_LOAD;
							end
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_no_out_in_load, (state_q == S_LOAD), !m_tvalid)
	`ASSERT_IMPL(a_last_valid, m_tlast && m_tvalid, (r_q == n1_q) && (c_q == n1_q))
	`ASSERT_NEXT(a_hold_until_taken, m_tvalid && !m_tready, m_tvalid)
endmodule

FILE: hdl/lup_decomposition.sv
// channel | dir | handshake           | word
// cfg     | in  | cfg_valid/cfg_ready | cfg_data: matrix_size[3:0]
// s       | in  | s_tvalid/s_tready   | s_tdata: elem_value[31:0]
// m       | out | m_tvalid/m_tready   | m_tdata: lu_value, row, col, perm; m_tuser: singular
// Loading accepts one word per cycle while cfg_valid is low; the last word starts the decomposition.
// Pivot search reads rows k to n-1 of column k; a row swap reads and writes back both rows element by element.
// Each multiplier comes from the bit-serial divider; each update passes through the
// single memory read port and the multiplier.
// Output words are read, registered and held until the receiver takes each; input is held off until done.
// Reset: order 8, identity permutation; cfg is taken only while loading and restarts load.
module lup_decomposition
	import lupd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data,     // matrix_size[3:0], zero fill
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,     // elem_value[31:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata,     // lu_value[31:0], row[34:32], col[37:35], perm[40:38], zero fill
	output logic m_tuser,            // singular
	output logic m_tlast
);
	ctl_cmd_t cmd;
	dp_sts_t sts;
	val_t rd_word;

	lupd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data[3:0]),
		.cfg_ready(cfg_ready), .s_tvalid(s_tvalid), .s_tready(s_tready), .cmd(cmd),
		.sts(sts), .rd_word(rd_word), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	lupd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(val_t'(s_tdata)),
		.sts(sts), .rd_word(rd_word)
	);
endmodule
